// ===== hdl/flpa_pkg.sv =====
// shared types and constants for the free-list pool allocator
// no dependencies; used by flpa_ctrl, flpa_dp and free_list_pool_allocator_core

package flpa_pkg;

  // field widths of the stream payloads
  localparam int unsigned SlotW   = 10;
  localparam int unsigned CountW  = 11;
  localparam int unsigned StatusW = 2;
  localparam int unsigned InDataW  = 16;  // slot_to_free, zero padded
  localparam int unsigned OutDataW = 24;  // granted_slot, slots_in_use, zero padded

  typedef enum logic {
    FUNC_ALLOC = 1'b0,
    FUNC_FREE  = 1'b1
  } func_e;

  typedef enum logic [StatusW-1:0] {
    ST_DONE      = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_BAD_FREE  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_INIT,
    S_IDLE,
    S_EXEC
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic init_wr;  // write one link of the clearing pass
    logic accept;   // capture the input transfer
    logic exec;     // perform the captured request, load the result register
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic init_last;  // clearing pass is at its last entry
  } dp_status_t;

endpackage

// ===== hdl/flpa_ctrl.sv =====
// controller state machine for the free-list pool allocator
// depends on flpa_pkg; drives the datapath through flpa_pkg::dp_cmd_t

module flpa_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  input  flpa_pkg::dp_status_t   status_i,
  output flpa_pkg::dp_cmd_t      cmd_o
);

  flpa_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             accept;

  // accept only while the result register is empty or being drained
  assign in_ready_o  = (state_q == flpa_pkg::S_IDLE) && (!out_valid_q || out_ready_i);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      flpa_pkg::S_INIT: begin
        if (status_i.init_last) state_d = flpa_pkg::S_IDLE;
      end
      flpa_pkg::S_IDLE: begin
        if (accept) state_d = flpa_pkg::S_EXEC;
      end
      flpa_pkg::S_EXEC: begin
        state_d = flpa_pkg::S_IDLE;
      end
      default: begin
        state_d = flpa_pkg::S_INIT;
      end
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      flpa_pkg::S_INIT: begin
        cmd_o.init_wr = 1'b1;
      end
      flpa_pkg::S_IDLE: begin
        cmd_o.accept = accept;
      end
      flpa_pkg::S_EXEC: begin
        cmd_o.exec  = 1'b1;
        out_valid_d = 1'b1;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= flpa_pkg::S_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== hdl/flpa_dp.sv =====
// datapath of the free-list pool allocator: link memory, head and count
// registers, clearing counter and result register; depends on flpa_pkg

module flpa_dp #(
  parameter int unsigned POOL_SLOTS = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  flpa_pkg::dp_cmd_t                   cmd_i,
  output flpa_pkg::dp_status_t                status_o,
  input  logic                                func_i,
  input  logic [flpa_pkg::SlotW-1:0]          slot_to_free_i,
  output logic [flpa_pkg::StatusW-1:0]        status_field_o,
  output logic [flpa_pkg::SlotW-1:0]          granted_slot_o,
  output logic [flpa_pkg::CountW-1:0]         slots_in_use_o
);

  localparam int unsigned IdxW = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
  localparam int unsigned PtrW = $clog2(POOL_SLOTS + 1);
  localparam logic [31:0] Slots32 = 32'(POOL_SLOTS);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(POOL_SLOTS - 1);

  logic [PtrW-1:0] link_mem [POOL_SLOTS];
  logic [PtrW-1:0] rdata_q;

  logic [IdxW-1:0] init_q, init_d;
  logic [PtrW-1:0] head_q, head_d;
  logic [PtrW-1:0] count_q, count_d;

  flpa_pkg::func_e func_q;
  logic [flpa_pkg::SlotW-1:0] slot_q;

  flpa_pkg::status_e          res_status_q, res_status_d;
  logic [flpa_pkg::SlotW-1:0] res_slot_q, res_slot_d;

  logic            mem_we;
  logic [IdxW-1:0] mem_waddr;
  logic [PtrW-1:0] mem_wdata;

  logic [31:0] head_w, count_w, slot_w, init_w;
  logic        exhausted, bad_free;

  assign head_w  = 32'(head_q);
  assign count_w = 32'(count_q);
  assign slot_w  = 32'(slot_q);
  assign init_w  = 32'(init_q);

  assign exhausted = (head_w >= Slots32) || (count_w >= Slots32);
  assign bad_free  = (slot_w >= Slots32) || (count_q == '0);

  assign status_o.init_last = (init_q == LastIdx);

  always_comb begin
    init_d       = init_q;
    head_d       = head_q;
    count_d      = count_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    mem_we       = 1'b0;
    mem_waddr    = init_q;
    mem_wdata    = PtrW'(init_w + 32'd1);
    if (cmd_i.init_wr) begin
      // clearing pass: each link points at the next slot
      mem_we = 1'b1;
      init_d = init_q + IdxW'(1);
    end
    if (cmd_i.exec) begin
      res_slot_d = '0;
      if (func_q == flpa_pkg::FUNC_ALLOC) begin
        if (exhausted) begin
          res_status_d = flpa_pkg::ST_EXHAUSTED;
        end else begin
          res_status_d = flpa_pkg::ST_DONE;
          res_slot_d   = head_w[flpa_pkg::SlotW-1:0];
          head_d       = rdata_q;
          count_d      = count_q + PtrW'(1);
        end
      end else begin
        if (bad_free) begin
          res_status_d = flpa_pkg::ST_BAD_FREE;
        end else begin
          res_status_d = flpa_pkg::ST_DONE;
          mem_we       = 1'b1;
          mem_waddr    = slot_w[IdxW-1:0];
          mem_wdata    = head_q;
          head_d       = PtrW'(slot_w);
          count_d      = count_q - PtrW'(1);
        end
      end
    end
  end

  // link memory; the head link is read every cycle so its registered read data is ready when the request executes
  always_ff @(posedge clk_i) begin
    if (mem_we) link_mem[mem_waddr] <= mem_wdata;
    rdata_q <= link_mem[head_q[IdxW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q  <= '0;
      head_q  <= '0;
      count_q <= '0;
    end else begin
      init_q  <= init_d;
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      func_q <= flpa_pkg::func_e'(func_i);
      slot_q <= slot_to_free_i;
    end
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
  end

  // count register is only written in exec, so it already holds the result count
  assign status_field_o = res_status_q;
  assign granted_slot_o = res_slot_q;
  assign slots_in_use_o = count_w[flpa_pkg::CountW-1:0];

endmodule

// ===== hdl/free_list_pool_allocator_core.sv =====
// Free-list pool allocator, top level.
// Requests enter on the s_axis channel: s_axis_tuser is the operation
// (0 allocate, 1 free), s_axis_tdata[9:0] the slot to return on a free.
// Every request gives exactly one result on the m_axis channel:
// m_axis_tuser is the status (0 done, 1 pool exhausted, 2 invalid free),
// m_axis_tdata holds the granted slot and the count of slots in use.
// A request passes through the transfer cycle, in which the link memory
// is read at the free-list head, and the execute state, which uses the
// registered read data and loads the result register that drives the
// m_axis channel. A new request is not taken before its predecessor has
// left the execute state.
// The result register parts the two sides: a new request is taken in the
// cycle its predecessor's result is taken. While the receiver stalls the
// result holds and s_axis_tready stays low.
// After reset the link memory is cleared, one entry per cycle, so that
// every link points at the next slot; s_axis_tready is low until all
// POOL_SLOTS entries (1024 by default) are written. Depends on flpa_pkg, flpa_ctrl, flpa_dp.

module free_list_pool_allocator_core #(
  parameter int unsigned POOL_SLOTS = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [9:0] slot_to_free, [15:10] zero
  input  logic        s_axis_tuser,   // [0] func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [9:0] granted_slot, [20:10] slots_in_use, [23:21] zero
  output logic [1:0]  m_axis_tuser    // [1:0] status
);

  flpa_pkg::dp_cmd_t    cmd;
  flpa_pkg::dp_status_t dp_status;

  logic [flpa_pkg::SlotW-1:0]  granted_slot;
  logic [flpa_pkg::CountW-1:0] slots_in_use;

  flpa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (dp_status),
    .cmd_o       (cmd)
  );

  flpa_dp #(
    .POOL_SLOTS (POOL_SLOTS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (dp_status),
    .func_i         (s_axis_tuser),
    .slot_to_free_i (s_axis_tdata[flpa_pkg::SlotW-1:0]),
    .status_field_o (m_axis_tuser),
    .granted_slot_o (granted_slot),
    .slots_in_use_o (slots_in_use)
  );

  assign m_axis_tdata = {3'b000, slots_in_use, granted_slot};

  // one request at a time: no transfer in the cycle after a transfer
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken while a request is executing");

  // a result only appears after a request was taken and executed
  a_result_follows_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("result without a request");

  // failed requests grant no slot
  a_fail_no_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser != flpa_pkg::ST_DONE)) |-> (m_axis_tdata[9:0] == 10'd0))
    else $error("slot granted on a failed request");

  // no datapath command during the clearing pass other than the link writes
  a_init_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.init_wr |-> (!cmd.exec && !s_axis_tready))
    else $error("request handled during clearing pass");

endmodule
